// ===== design/overwriting_event_log_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Event log assertion macros
// Concurrent assertion wrappers shared by the event log modules.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_EVENT_LOG_UNIT_MACROS_SVH
`define OVERWRITING_EVENT_LOG_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// plain property, checked out of reset
`define OEL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, checked out of reset
`define OEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define OEL_ASSERT(lbl, clk, rst_n, prop, msg)
`define OEL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/oel_pkg.sv =====
// ----------------------------------------------------------------------------
// Event log package
// Shared widths, command codes, item types and helpers of the event log.
// ----------------------------------------------------------------------------
package oel_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int STAMP_W  = 64;
    localparam int SEQ_W    = 32;
    localparam int CODE_W   = 8;
    localparam int LEVEL_W  = 3;
    localparam int DETAIL_W = 32;
    localparam int POS_W    = 8;
    localparam int OCC_W    = 6;
    localparam int CNT_W    = 32;

    // result queue between front and back
    localparam int Q_DEPTH  = 4;
    localparam int QP_W     = $clog2(Q_DEPTH);
    localparam int QC_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVICE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CFG_FAIL = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [SEQ_W-1:0]    seq;
        logic [CODE_W-1:0]   code;
        logic [LEVEL_W-1:0]  level;
        logic [DETAIL_W-1:0] detail;
    } entry_t;

    typedef struct packed {
        logic               ok;
        logic               is_read;
        logic [OCC_W-1:0]   occupancy;
        logic [CNT_W-1:0]   drops;
        logic [OCC_W-1:0]   peak;
        logic [CNT_W-1:0]   service;
        logic [CNT_W-1:0]   cfg_fail;
    } ctrl_t;

    typedef struct packed {
        ctrl_t  ctrl;
        entry_t ent;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== design/oel_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/oel_front.sv =====
// ----------------------------------------------------------------------------
// Event log front end
// Accepts commands, keeps ring pointers and counters, drives the entry RAM.
// ----------------------------------------------------------------------------
`include "overwriting_event_log_unit_macros.svh"

module oel_front import oel_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [CMD_W-1:0]              s_command,
    input  logic [STAMP_W-1:0]            s_stamp_us,
    input  logic [CODE_W-1:0]             s_event_code,
    input  logic [LEVEL_W-1:0]            s_event_level,
    input  logic [DETAIL_W-1:0]           s_event_detail,
    input  logic [POS_W-1:0]              s_read_position,
    input  logic                          room,
    output logic                          issue,
    output ctrl_t                         issue_ctrl,
    output logic                          ram_we,
    output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
    output entry_t                        ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]   ram_raddr
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int PW = (FW > POS_W) ? FW : POS_W;

    logic [AW-1:0]    oldest_reg, oldest_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [CNT_W-1:0] drops_reg, drops_next;
    logic [FW-1:0]    peak_reg, peak_next;
    logic [CNT_W-1:0] svc_reg, svc_next;
    logic [CNT_W-1:0] cfail_reg, cfail_next;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] fill_ext;
    logic          acc;
    logic          ok;
    logic          is_read;

    // (a + b) mod CAPACITY, both operands below CAPACITY
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign s_ready  = room;
    assign acc      = s_valid && s_ready;
    assign pos_ext  = PW'(s_read_position);
    assign fill_ext = PW'(fill_reg);

    always_comb begin
        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        seq_next    = seq_reg;
        drops_next  = drops_reg;
        peak_next   = peak_reg;
        svc_next    = svc_reg;
        cfail_next  = cfail_reg;
        ram_we      = 1'b0;
        ram_waddr   = oldest_reg;
        ok          = 1'b1;
        is_read     = 1'b0;
        if (acc) begin
            unique case (s_command)
                CMD_PUSH: begin
                    ram_we = 1'b1;
                    if (fill_reg < FW'(CAPACITY)) begin
                        ram_waddr = wrap(oldest_reg, AW'(fill_reg));
                        fill_next = fill_reg + FW'(1);
                    end else begin
                        // full: overwrite oldest
                        ram_waddr   = oldest_reg;
                        oldest_next = wrap(oldest_reg, AW'(1));
                        drops_next  = sat_inc(drops_reg);
                    end
                    seq_next = (seq_reg == '1) ? SEQ_W'(1) : seq_reg + SEQ_W'(1);
                    if (peak_reg < fill_next) begin
                        peak_next = fill_next;
                    end
                end
                CMD_READ: begin
                    is_read = 1'b1;
                    ok      = (pos_ext < fill_ext);
                end
                CMD_SERVICE: begin
                    svc_next = sat_inc(svc_reg);
                end
                CMD_CFG_FAIL: begin
                    cfail_next = sat_inc(cfail_reg);
                end
            endcase
        end
    end

    // pos only matters when below fill, so it fits the slot width then
    assign ram_raddr = wrap(oldest_reg, AW'(pos_ext));

    assign ram_wdata = '{stamp:  s_stamp_us,
                         seq:    seq_reg,
                         code:   s_event_code,
                         level:  s_event_level,
                         detail: s_event_detail};

    assign issue = acc;
    assign issue_ctrl = '{ok:        ok,
                          is_read:   is_read,
                          occupancy: OCC_W'(fill_next),
                          drops:     drops_next,
                          peak:      OCC_W'(peak_next),
                          service:   svc_next,
                          cfg_fail:  cfail_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            fill_reg   <= '0;
            seq_reg    <= SEQ_W'(1);
            drops_reg  <= '0;
            peak_reg   <= '0;
            svc_reg    <= '0;
            cfail_reg  <= '0;
        end else begin
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
            seq_reg    <= seq_next;
            drops_reg  <= drops_next;
            peak_reg   <= peak_next;
            svc_reg    <= svc_next;
            cfail_reg  <= cfail_next;
        end
    end

    `OEL_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FW'(CAPACITY), "fill above capacity")
    `OEL_ASSERT(a_peak_ge_fill, aclk, aresetn, peak_reg >= fill_reg, "peak below current fill")
    `OEL_ASSERT(a_seq_nonzero, aclk, aresetn, seq_reg != '0, "sequence number reached zero")
    `OEL_ASSERT_IMPL(a_oldest_still, aclk, aresetn, fill_reg != FW'(CAPACITY), oldest_next == oldest_reg, "oldest moved before log was full")

endmodule

// ===== design/oel_back.sv =====
// ----------------------------------------------------------------------------
// Event log back end
// Joins RAM read data with command status and queues results for output.
// ----------------------------------------------------------------------------
`include "overwriting_event_log_unit_macros.svh"

module oel_back import oel_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  issue,
    input  ctrl_t                 issue_ctrl,
    input  entry_t                ram_rdata,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [STAMP_W-1:0]    m_out_stamp_us,
    output logic [SEQ_W-1:0]      m_out_sequence,
    output logic [CODE_W-1:0]     m_out_code,
    output logic [LEVEL_W-1:0]    m_out_level,
    output logic [DETAIL_W-1:0]   m_out_detail,
    output logic [OCC_W-1:0]      m_occupancy,
    output logic [CNT_W-1:0]      m_drops,
    output logic [OCC_W-1:0]      m_peak_occupancy,
    output logic [CNT_W-1:0]      m_service_total,
    output logic [CNT_W-1:0]      m_config_fail_total
);

    logic        stage_valid_reg;
    ctrl_t       stage_ctrl_reg;
    result_t     queue_reg [Q_DEPTH];
    logic [QP_W-1:0] head_reg, tail_reg;
    logic [QC_W-1:0] count_reg, count_next;
    logic [QC_W-1:0] pending;
    result_t     push_item;
    result_t     head_item;
    logic        push;
    logic        pop;

    // slots already spoken for: queued plus the one waiting on RAM data
    assign pending = count_reg + QC_W'(stage_valid_reg);
    assign room    = (pending < QC_W'(Q_DEPTH));

    assign push = stage_valid_reg;
    assign pop  = m_valid && m_ready;

    always_comb begin
        push_item.ctrl = stage_ctrl_reg;
        push_item.ent  = (stage_ctrl_reg.is_read && stage_ctrl_reg.ok) ? ram_rdata : '0;
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QC_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
        end else begin
            stage_valid_reg <= issue;
            count_reg       <= count_next;
            if (push) begin
                tail_reg <= tail_reg + QP_W'(1);
            end
            if (pop) begin
                head_reg <= head_reg + QP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            stage_ctrl_reg <= issue_ctrl;
        end
        if (push) begin
            queue_reg[tail_reg] <= push_item;
        end
    end

    assign head_item = queue_reg[head_reg];

    assign m_valid             = (count_reg != '0);
    assign m_ok                = head_item.ctrl.ok;
    assign m_out_stamp_us      = head_item.ent.stamp;
    assign m_out_sequence      = head_item.ent.seq;
    assign m_out_code          = head_item.ent.code;
    assign m_out_level         = head_item.ent.level;
    assign m_out_detail        = head_item.ent.detail;
    assign m_occupancy         = head_item.ctrl.occupancy;
    assign m_drops             = head_item.ctrl.drops;
    assign m_peak_occupancy    = head_item.ctrl.peak;
    assign m_service_total     = head_item.ctrl.service;
    assign m_config_fail_total = head_item.ctrl.cfg_fail;

    `OEL_ASSERT(a_count_bound, aclk, aresetn, count_reg <= QC_W'(Q_DEPTH), "result queue overfilled")
    `OEL_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push && count_reg == QC_W'(Q_DEPTH), pop, "push into full result queue")
    `OEL_ASSERT_IMPL(a_fail_zeroed, aclk, aresetn, m_valid && !m_ok, m_out_sequence == '0 && m_out_stamp_us == '0, "failed read carries entry data")

endmodule

// ===== design/overwriting_event_log_unit.sv =====
// ----------------------------------------------------------------------------
// Overwriting event log unit
// Circular event log with overwrite of the oldest entry and status counters.
// ----------------------------------------------------------------------------
// The unit takes one command per cycle while s_ready is high and returns one
// result per command, in order, through the registered read of the entry RAM
// and then the four-entry result queue. The front end updates pointers and
// counters as the item is accepted, so back-to-back pushes and reads of fresh
// entries run at full rate; s_ready drops only when the result queue and the
// RAM read stage together hold four results that m_ready has not taken yet.
module overwriting_event_log_unit import oel_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [STAMP_W-1:0]    s_stamp_us,
    input  logic [CODE_W-1:0]     s_event_code,
    input  logic [LEVEL_W-1:0]    s_event_level,
    input  logic [DETAIL_W-1:0]   s_event_detail,
    input  logic [POS_W-1:0]      s_read_position,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_ok,
    output logic [STAMP_W-1:0]    m_out_stamp_us,
    output logic [SEQ_W-1:0]      m_out_sequence,
    output logic [CODE_W-1:0]     m_out_code,
    output logic [LEVEL_W-1:0]    m_out_level,
    output logic [DETAIL_W-1:0]   m_out_detail,
    output logic [OCC_W-1:0]      m_occupancy,
    output logic [CNT_W-1:0]      m_drops,
    output logic [OCC_W-1:0]      m_peak_occupancy,
    output logic [CNT_W-1:0]      m_service_total,
    output logic [CNT_W-1:0]      m_config_fail_total
);

    localparam int AW = $clog2(CAPACITY);

    logic          room;
    logic          issue;
    ctrl_t         issue_ctrl;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    oel_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_stamp_us      (s_stamp_us),
        .s_event_code    (s_event_code),
        .s_event_level   (s_event_level),
        .s_event_detail  (s_event_detail),
        .s_read_position (s_read_position),
        .room            (room),
        .issue           (issue),
        .issue_ctrl      (issue_ctrl),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr)
    );

    oel_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    oel_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .issue               (issue),
        .issue_ctrl          (issue_ctrl),
        .ram_rdata           (ram_rdata),
        .room                (room),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_ok                (m_ok),
        .m_out_stamp_us      (m_out_stamp_us),
        .m_out_sequence      (m_out_sequence),
        .m_out_code          (m_out_code),
        .m_out_level         (m_out_level),
        .m_out_detail        (m_out_detail),
        .m_occupancy         (m_occupancy),
        .m_drops             (m_drops),
        .m_peak_occupancy    (m_peak_occupancy),
        .m_service_total     (m_service_total),
        .m_config_fail_total (m_config_fail_total)
    );

endmodule

// ===== test/event_log_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event log checker
// Watches both channels of the event log, keeps its own copy of the log and
// its counters, predicts one result per accepted command and compares each
// returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module event_log_checker import oel_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [STAMP_W-1:0]  s_stamp_us,
    input  logic [CODE_W-1:0]   s_event_code,
    input  logic [LEVEL_W-1:0]  s_event_level,
    input  logic [DETAIL_W-1:0] s_event_detail,
    input  logic [POS_W-1:0]    s_read_position,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_ok,
    input  logic [STAMP_W-1:0]  m_out_stamp_us,
    input  logic [SEQ_W-1:0]    m_out_sequence,
    input  logic [CODE_W-1:0]   m_out_code,
    input  logic [LEVEL_W-1:0]  m_out_level,
    input  logic [DETAIL_W-1:0] m_out_detail,
    input  logic [OCC_W-1:0]    m_occupancy,
    input  logic [CNT_W-1:0]    m_drops,
    input  logic [OCC_W-1:0]    m_peak_occupancy,
    input  logic [CNT_W-1:0]    m_service_total,
    input  logic [CNT_W-1:0]    m_config_fail_total,
    output int                  mismatches,
    output int                  outstanding
);

    localparam int LOG_DEPTH  = CAPACITY_DEF;

    typedef struct {
        logic                ok;
        logic [STAMP_W-1:0]  stamp;
        logic [SEQ_W-1:0]    seq;
        logic [CODE_W-1:0]   code;
        logic [LEVEL_W-1:0]  level;
        logic [DETAIL_W-1:0] detail;
        logic [OCC_W-1:0]    occupancy;
        logic [CNT_W-1:0]    drops;
        logic [OCC_W-1:0]    peak;
        logic [CNT_W-1:0]    service;
        logic [CNT_W-1:0]    cfg_fail;
    } log_result_t;

    entry_t          log_mem [LOG_DEPTH];
    int              oldest;
    int              fill;
    logic [SEQ_W-1:0] next_seq;
    logic [CNT_W-1:0] drop_cnt;
    int              peak_fill;
    logic [CNT_W-1:0] service_cnt;
    logic [CNT_W-1:0] cfg_fail_cnt;

    log_result_t     expected_results[$];
    int              err_cnt = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    task automatic clear_log();
        oldest       = 0;
        fill         = 0;
        next_seq     = SEQ_W'(1);
        drop_cnt     = '0;
        peak_fill    = 0;
        service_cnt  = '0;
        cfg_fail_cnt = '0;
        expected_results.delete();
    endtask

    // applies one command to the log copy and queues the result it must give
    task automatic predict_log_result();
        log_result_t r;
        int          slot;
        r = '{default: '0};
        r.ok = 1'b1;
        case (s_command)
            CMD_PUSH: begin
                if (fill < LOG_DEPTH) begin
                    slot = (oldest + fill) % LOG_DEPTH;
                    fill++;
                end else begin
                    // full: overwrite the oldest entry
                    slot     = oldest;
                    oldest   = (oldest + 1) % LOG_DEPTH;
                    drop_cnt = bump(drop_cnt);
                end
                log_mem[slot].stamp  = s_stamp_us;
                log_mem[slot].seq    = next_seq;
                log_mem[slot].code   = s_event_code;
                log_mem[slot].level  = s_event_level;
                log_mem[slot].detail = s_event_detail;
                next_seq = next_seq + SEQ_W'(1);
                if (next_seq == '0) next_seq = SEQ_W'(1);
                if (peak_fill < fill) peak_fill = fill;
            end
            CMD_READ: begin
                if (int'(s_read_position) >= fill) begin
                    r.ok = 1'b0;
                end else begin
                    slot     = (oldest + int'(s_read_position)) % LOG_DEPTH;
                    r.stamp  = log_mem[slot].stamp;
                    r.seq    = log_mem[slot].seq;
                    r.code   = log_mem[slot].code;
                    r.level  = log_mem[slot].level;
                    r.detail = log_mem[slot].detail;
                end
            end
            CMD_SERVICE:  service_cnt  = bump(service_cnt);
            CMD_CFG_FAIL: cfg_fail_cnt = bump(cfg_fail_cnt);
            default: ;
        endcase
        r.occupancy = OCC_W'(fill);
        r.drops     = drop_cnt;
        r.peak      = OCC_W'(peak_fill);
        r.service   = service_cnt;
        r.cfg_fail  = cfg_fail_cnt;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        log_result_t e;
        if (!aresetn) begin
            clear_log();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with none expected, %s ok=%0b occ=%0d",
                             $time, "expected nothing, got", m_ok, m_occupancy);
                    err_cnt++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("ok", 64'(e.ok), 64'(m_ok));
                    check_field("out_stamp_us", e.stamp, m_out_stamp_us);
                    check_field("out_sequence", 64'(e.seq), 64'(m_out_sequence));
                    check_field("out_code", 64'(e.code), 64'(m_out_code));
                    check_field("out_level", 64'(e.level), 64'(m_out_level));
                    check_field("out_detail", 64'(e.detail), 64'(m_out_detail));
                    check_field("occupancy", 64'(e.occupancy), 64'(m_occupancy));
                    check_field("drops", 64'(e.drops), 64'(m_drops));
                    check_field("peak_occupancy", 64'(e.peak), 64'(m_peak_occupancy));
                    check_field("service_total", 64'(e.service), 64'(m_service_total));
                    check_field("config_fail_total", 64'(e.cfg_fail),
                                64'(m_config_fail_total));
                end
            end
            if (s_valid && s_ready)
                predict_log_result();
        end
        outstanding <= expected_results.size();
        mismatches  <= err_cnt;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event log unit testbench
// Drives directed and random commands into the event log under varying idle
// patterns and a long result back-pressure stretch; the checker predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import oel_pkg::*; ();

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 370;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command = CMD_PUSH;
    logic [STAMP_W-1:0]  s_stamp_us = '0;
    logic [CODE_W-1:0]   s_event_code = '0;
    logic [LEVEL_W-1:0]  s_event_level = '0;
    logic [DETAIL_W-1:0] s_event_detail = '0;
    logic [POS_W-1:0]    s_read_position = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic [STAMP_W-1:0]  m_out_stamp_us;
    logic [SEQ_W-1:0]    m_out_sequence;
    logic [CODE_W-1:0]   m_out_code;
    logic [LEVEL_W-1:0]  m_out_level;
    logic [DETAIL_W-1:0] m_out_detail;
    logic [OCC_W-1:0]    m_occupancy;
    logic [CNT_W-1:0]    m_drops;
    logic [OCC_W-1:0]    m_peak_occupancy;
    logic [CNT_W-1:0]    m_service_total;
    logic [CNT_W-1:0]    m_config_fail_total;

    int mismatches;
    int outstanding;

    int tx_idle_pct = 33;
    int rx_idle_pct = 59;
    int hold_ask    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    overwriting_event_log_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_stamp_us         (s_stamp_us),
        .s_event_code       (s_event_code),
        .s_event_level      (s_event_level),
        .s_event_detail     (s_event_detail),
        .s_read_position    (s_read_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_out_stamp_us     (m_out_stamp_us),
        .m_out_sequence     (m_out_sequence),
        .m_out_code         (m_out_code),
        .m_out_level        (m_out_level),
        .m_out_detail       (m_out_detail),
        .m_occupancy        (m_occupancy),
        .m_drops            (m_drops),
        .m_peak_occupancy   (m_peak_occupancy),
        .m_service_total    (m_service_total),
        .m_config_fail_total(m_config_fail_total)
    );

    event_log_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_stamp_us         (s_stamp_us),
        .s_event_code       (s_event_code),
        .s_event_level      (s_event_level),
        .s_event_detail     (s_event_detail),
        .s_read_position    (s_read_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ok               (m_ok),
        .m_out_stamp_us     (m_out_stamp_us),
        .m_out_sequence     (m_out_sequence),
        .m_out_code         (m_out_code),
        .m_out_level        (m_out_level),
        .m_out_detail       (m_out_detail),
        .m_occupancy        (m_occupancy),
        .m_drops            (m_drops),
        .m_peak_occupancy   (m_peak_occupancy),
        .m_service_total    (m_service_total),
        .m_config_fail_total(m_config_fail_total),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("overwriting_event_log_unit: mismatch");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [STAMP_W-1:0] stamp,
                            input logic [CODE_W-1:0] code, input logic [LEVEL_W-1:0] level,
                            input logic [DETAIL_W-1:0] detail, input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_stamp_us      <= stamp;
        s_event_code    <= code;
        s_event_level   <= level;
        s_event_detail  <= detail;
        s_read_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_cmds(input int count);
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        int               pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45)      cmd = CMD_PUSH;
            else if (pick < 80) cmd = CMD_READ;
            else if (pick < 90) cmd = CMD_SERVICE;
            else                cmd = CMD_CFG_FAIL;
            // mostly positions around the live range, some anywhere
            if ($urandom_range(99) < 80) pos = POS_W'($urandom_range(40));
            else                         pos = POS_W'($urandom);
            send_cmd(cmd, {$urandom, $urandom}, CODE_W'($urandom), LEVEL_W'($urandom),
                     $urandom, pos);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty log reads, counters, field extremes, out-of-range reads
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd0);
        send_cmd(CMD_READ, '1, '1, '1, '1, 8'hFF);
        send_cmd(CMD_SERVICE, '0, '0, '0, '0, '0);
        send_cmd(CMD_CFG_FAIL, '0, '0, '0, '0, '0);
        send_cmd(CMD_PUSH, '0, '0, '0, '0, '0);
        send_cmd(CMD_PUSH, '1, '1, '1, '1, '1);
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd0);
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd1);
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd2);
        send_cmd(CMD_PUSH, 64'h0123_4567_89AB_CDEF, 8'h5A, 3'd3, 32'hDEAD_BEEF, '0);
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd2);
        send_cmd(CMD_SERVICE, '1, '1, '1, '1, '1);
        send_cmd(CMD_CFG_FAIL, '1, '1, '1, '1, '1);
        // fill past capacity so the oldest entries get overwritten
        repeat (CAPACITY_DEF + 2)
            send_cmd(CMD_PUSH, {$urandom, $urandom}, CODE_W'($urandom), LEVEL_W'($urandom),
                     $urandom, '0);
        send_cmd(CMD_READ, '0, '0, '0, '0, 8'd0);
        send_cmd(CMD_READ, '0, '0, '0, '0, POS_W'(CAPACITY_DEF - 1));
        send_cmd(CMD_READ, '0, '0, '0, '0, POS_W'(CAPACITY_DEF));

        send_random_cmds(PHASE_ITEMS);

        tx_idle_pct = 59;
        rx_idle_pct = 33;
        send_random_cmds(PHASE_ITEMS);

        // no idling; a long result stall backs the unit up into its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_ask++;
        send_random_cmds(PHASE_ITEMS);

        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("overwriting_event_log_unit: match");
        else
            $display("overwriting_event_log_unit: mismatch");
        $finish;
    end

endmodule
